@@ src/vpo_pkg.sv @@
// Shared types, constants and helpers of the vertex projection and outcode unit.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package vpo_pkg;

  localparam int unsigned FracBitsDef = 16;
  localparam int unsigned DataW       = 32;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned NumLanes    = 3;
  localparam int unsigned OcW         = 6;
  localparam int unsigned SatW        = 80;

  // Screen z scale, applied as a negative factor
  localparam logic [15:0] ZScale = 16'd32767;

  // Item commands
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_POINT = 1'b1;

  // Outcode bit positions
  localparam int unsigned OC_RIGHT  = 0;
  localparam int unsigned OC_LEFT   = 1;
  localparam int unsigned OC_TOP    = 2;
  localparam int unsigned OC_BOTTOM = 3;
  localparam int unsigned OC_HITHER = 4;
  localparam int unsigned OC_YON    = 5;

  // Divider lanes
  localparam int unsigned LANE_X = 0;
  localparam int unsigned LANE_Y = 1;
  localparam int unsigned LANE_Z = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ORIGIN_X    = 3'd0,
    CFG_ORIGIN_Y    = 3'd1,
    CFG_SCALE_X     = 3'd2,
    CFG_SCALE_Y     = 3'd3,
    CFG_PROJECT_ALL = 3'd4
  } cfg_idx_e;

  // Per-item flags that ride along the divider
  typedef struct packed {
    logic [OcW-1:0]      outcode;
    logic                projected;
    logic                behind_eye;
    logic                w_zero;
    logic                last;
    logic [NumLanes-1:0] neg;
  } side_t;

  // Clamp a wide signed value to 32 bit signed
  function automatic logic signed [DataW-1:0] sat32(input logic signed [SatW-1:0] v);
    logic signed [SatW-1:0] hi;
    logic signed [SatW-1:0] lo;
    hi = 80'sd2147483647;
    lo = -80'sd2147483648;
    if (v > hi) begin
      return 32'sh7FFF_FFFF;
    end else if (v < lo) begin
      return 32'sh8000_0000;
    end
    return v[DataW-1:0];
  endfunction

endpackage

`default_nettype wire

@@ src/vpo_xform.sv @@
// Matrix store and row-vector transform: products in the first stage, sums in the second.
// Depends on vpo_pkg.
`default_nettype none

module vpo_xform #(
  parameter int unsigned FracBits = vpo_pkg::FracBitsDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic                               valid_i,
  input  logic                               cmd_i,
  input  logic [3:0]                         entry_index_i,
  input  logic signed [vpo_pkg::DataW-1:0]   entry_value_i,
  input  logic signed [vpo_pkg::DataW-1:0]   point_x_i,
  input  logic signed [vpo_pkg::DataW-1:0]   point_y_i,
  input  logic signed [vpo_pkg::DataW-1:0]   point_z_i,
  input  logic                               last_i,
  output logic                               valid_o,
  output logic signed [vpo_pkg::DataW-1:0]   sp_o [4],
  output logic                               last_o
);
  import vpo_pkg::*;

  localparam logic signed [DataW-1:0] One = DataW'(1) << FracBits;

  logic signed [DataW-1:0]   m_q [16];
  logic signed [DataW-1:0]   pt [3];
  logic signed [2*DataW-1:0] prod_d [4][3];
  logic signed [2*DataW-1:0] prod_q [4][3];
  logic signed [DataW-1:0]   r3_q [4];
  logic                      v1_q, last1_q;
  logic signed [DataW-1:0]   sp_d [4];
  logic signed [DataW-1:0]   sp_q [4];
  logic                      v2_q, last2_q;
  logic signed [SatW-1:0]    acc;

  // Hold the matrix; load items write one entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 16; i++) begin
        m_q[i] <= (i % 5 == 0) ? One : '0;
      end
    end else if (valid_i && en_i && cmd_i == CMD_LOAD) begin
      m_q[entry_index_i] <= entry_value_i;
    end
  end

  // Form the twelve point-by-entry products
  always_comb begin
    pt[0] = point_x_i;
    pt[1] = point_y_i;
    pt[2] = point_z_i;
    for (int j = 0; j < 4; j++) begin
      for (int k = 0; k < 3; k++) begin
        prod_d[j][k] = (2*DataW)'(pt[k]) * (2*DataW)'(m_q[k*4+j]);
      end
    end
  end

  // Sum floored products with the translation row and clamp
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      acc = SatW'(r3_q[j]);
      for (int k = 0; k < 3; k++) begin
        acc = acc + SatW'(prod_q[j][k] >>> FracBits);
      end
      sp_d[j] = sat32(acc);
    end
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i && cmd_i == CMD_POINT;
      v2_q <= v1_q;
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q  <= prod_d;
      for (int j = 0; j < 4; j++) begin
        r3_q[j] <= m_q[12+j];
      end
      last1_q <= last_i;
      sp_q    <= sp_d;
      last2_q <= last1_q;
    end
  end

  assign valid_o = v2_q;
  assign sp_o    = sp_q;
  assign last_o  = last2_q;

endmodule

`default_nettype wire

@@ src/vpo_div.sv @@
// Pipelined unsigned restoring divider: three lanes share one divisor, one bit per stage.
// Depends on vpo_pkg for the lane count and the flag struct carried alongside.
`default_nettype none

module vpo_div #(
  parameter int unsigned DivW = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic [DivW-1:0]            num_i [vpo_pkg::NumLanes],
  input  logic [vpo_pkg::DataW-1:0]  den_i,
  input  vpo_pkg::side_t             side_i,
  output logic                       valid_o,
  output logic [DivW-1:0]            quot_o [vpo_pkg::NumLanes],
  output vpo_pkg::side_t             side_o
);
  import vpo_pkg::*;

  logic [DivW-1:0]  num_q [DivW][NumLanes];
  logic [DataW-1:0] rem_q [DivW][NumLanes];
  logic [DataW-1:0] den_q [DivW];
  side_t            side_q [DivW];
  logic             vld_q [DivW];

  // One quotient bit: shift in a numerator bit, subtract if it fits
  function automatic logic [DataW+DivW-1:0] div_step(input logic [DataW-1:0] rem,
                                                      input logic [DivW-1:0]  num,
                                                      input logic [DataW-1:0] den);
    logic [DataW:0] t;
    logic           qb;
    t  = {rem, num[DivW-1]};
    qb = 1'b0;
    if (t >= {1'b0, den}) begin
      t  = t - {1'b0, den};
      qb = 1'b1;
    end
    return {t[DataW-1:0], num[DivW-2:0], qb};
  endfunction

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < DivW; s++) begin
        vld_q[s] <= 1'b0;
      end
    end else if (en_i) begin
      vld_q[0] <= valid_i;
      for (int s = 1; s < DivW; s++) begin
        vld_q[s] <= vld_q[s-1];
      end
    end
  end

  // Advance remainders, quotients and flags
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den_q[0]  <= den_i;
      side_q[0] <= side_i;
      for (int l = 0; l < NumLanes; l++) begin
        {rem_q[0][l], num_q[0][l]} <= div_step('0, num_i[l], den_i);
      end
      for (int s = 1; s < DivW; s++) begin
        den_q[s]  <= den_q[s-1];
        side_q[s] <= side_q[s-1];
        for (int l = 0; l < NumLanes; l++) begin
          {rem_q[s][l], num_q[s][l]} <= div_step(rem_q[s-1][l], num_q[s-1][l], den_q[s-1]);
        end
      end
    end
  end

  assign valid_o = vld_q[DivW-1];
  assign quot_o  = num_q[DivW-1];
  assign side_o  = side_q[DivW-1];

endmodule

`default_nettype wire

@@ src/vertex_project_outcode_unit.sv @@
// Vertex projection with clip outcodes: transform, plane tests, divide and screen mapping.
// Depends on vpo_pkg, vpo_xform and vpo_div.
//
// Usage: items enter on the in channel (in_valid_i / in_stall_o) and results leave on
// the out channel (out_valid_o / out_stall_i). A load item (cmd 0) writes one matrix
// entry at its acceptance and gives no result; a point item (cmd 1) gives exactly one
// result, in order. Viewport registers are written through cfg_we_i / cfg_index_i /
// cfg_data_i; the user must write them only while the unit holds no item, which the
// unit does not enforce; an index above four is ignored. Throughput is one item per
// cycle unless stalled. A point passes through two transform stages, plane test and
// numerator products, operand conditioning, DivW divider stages (one quotient bit
// each, DivW the larger of 64 and 47 + fraction bits) and the output register.
// Reset loads the identity matrix, zero origins, unit scales and clears project_all;
// the pipeline comes up empty. While the receiver stalls a waiting result, the whole
// pipeline holds and in_stall_o is raised; nothing is lost or repeated.
`default_nettype none

module vertex_project_outcode_unit #(
  parameter int unsigned FracBits = vpo_pkg::FracBitsDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               cmd_i,
  input  logic [3:0]                         entry_index_i,
  input  logic signed [vpo_pkg::DataW-1:0]   entry_value_i,
  input  logic signed [vpo_pkg::DataW-1:0]   point_x_i,
  input  logic signed [vpo_pkg::DataW-1:0]   point_y_i,
  input  logic signed [vpo_pkg::DataW-1:0]   point_z_i,
  input  logic                               last_in_batch_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [vpo_pkg::OcW-1:0]            outcode_o,
  output logic signed [vpo_pkg::DataW-1:0]   screen_x_o,
  output logic signed [vpo_pkg::DataW-1:0]   screen_y_o,
  output logic signed [vpo_pkg::DataW-1:0]   screen_z_o,
  output logic                               projected_o,
  output logic                               behind_eye_o,
  output logic                               w_zero_o,
  output logic                               last_of_batch_o,
  input  logic                               cfg_we_i,
  input  logic [vpo_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [vpo_pkg::DataW-1:0]          cfg_data_i
);
  import vpo_pkg::*;

  localparam int unsigned DivW = (47 + FracBits > 64) ? 47 + FracBits : 64;
  localparam int unsigned ZW   = 48;

  logic                    adv;
  logic signed [DataW-1:0] offset_x_q, offset_y_q, scale_x_q, scale_y_q;
  logic                    project_all_q;

  logic                    sp_valid, sp_last;
  logic signed [DataW-1:0] sp [4];

  // Plane test and numerator products
  logic signed [DataW:0]     w33, negw;
  logic [OcW-1:0]            oc;
  logic                      v3_q;
  logic signed [2*DataW-1:0] px3_q, py3_q;
  logic signed [ZW-1:0]      pz3_q;
  logic signed [DataW-1:0]   w3_q;
  side_t                     side_d, side3_q;

  // Operand conditioning
  logic [2*DataW-1:0] magx, magy;
  logic [ZW-1:0]      magz;
  logic               numz_neg;
  logic               v4_q;
  logic [DivW-1:0]    num4_q [NumLanes];
  logic [DataW-1:0]   den4_q;
  side_t              side4_d, side4_q;

  // Divider results and output
  logic               dv_valid;
  logic [DivW-1:0]    quot [NumLanes];
  side_t              dv_side;
  logic signed [DivW:0] qs [NumLanes];
  logic                 out_valid_q;

  // Move the pipeline whenever the output register is free or being taken
  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = !adv;

  // Decode register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_x_q    <= '0;
      offset_y_q    <= '0;
      scale_x_q     <= DataW'(65536);
      scale_y_q     <= DataW'(65536);
      project_all_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_ORIGIN_X:    offset_x_q    <= cfg_data_i;
        CFG_ORIGIN_Y:    offset_y_q    <= cfg_data_i;
        CFG_SCALE_X:     scale_x_q     <= cfg_data_i;
        CFG_SCALE_Y:     scale_y_q     <= cfg_data_i;
        CFG_PROJECT_ALL: project_all_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  vpo_xform #(.FracBits(FracBits)) u_xform (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (adv),
    .valid_i       (in_valid_i),
    .cmd_i         (cmd_i),
    .entry_index_i (entry_index_i),
    .entry_value_i (entry_value_i),
    .point_x_i     (point_x_i),
    .point_y_i     (point_y_i),
    .point_z_i     (point_z_i),
    .last_i        (last_in_batch_i),
    .valid_o       (sp_valid),
    .sp_o          (sp),
    .last_o        (sp_last)
  );

  // Test the six planes at full width and set the flags
  always_comb begin
    w33  = (DataW+1)'(sp[3]);
    negw = -w33;
    oc = '0;
    oc[OC_RIGHT]  = (DataW+1)'(sp[0]) >= w33;
    oc[OC_LEFT]   = (DataW+1)'(sp[0]) < negw;
    oc[OC_TOP]    = (DataW+1)'(sp[1]) >= w33;
    oc[OC_BOTTOM] = (DataW+1)'(sp[1]) < negw;
    oc[OC_HITHER] = (DataW+1)'(sp[2]) >= w33;
    oc[OC_YON]    = (DataW+1)'(sp[2]) < negw;
    side_d            = '0;
    side_d.outcode    = oc;
    side_d.w_zero     = sp[3] == '0;
    side_d.projected  = (oc == '0 || project_all_q) && sp[3] != '0;
    side_d.behind_eye = sp[2] > 0;
    side_d.last       = sp_last;
  end

  // Strip signs for the divider and work out the quotient signs
  always_comb begin
    magx     = px3_q[2*DataW-1] ? 64'(-px3_q) : 64'(px3_q);
    magy     = py3_q[2*DataW-1] ? 64'(-py3_q) : 64'(py3_q);
    magz     = pz3_q[ZW-1] ? ZW'(-pz3_q) : ZW'(pz3_q);
    numz_neg = !pz3_q[ZW-1] && (pz3_q != '0);
    side4_d             = side3_q;
    side4_d.neg[LANE_X] = px3_q[2*DataW-1] ^ w3_q[DataW-1];
    side4_d.neg[LANE_Y] = py3_q[2*DataW-1] ^ w3_q[DataW-1];
    side4_d.neg[LANE_Z] = numz_neg ^ w3_q[DataW-1];
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      v3_q        <= sp_valid;
      v4_q        <= v3_q;
      out_valid_q <= dv_valid;
    end
  end

  // Advance payload of the test and conditioning stages
  always_ff @(posedge clk_i) begin
    if (adv) begin
      px3_q   <= (2*DataW)'(scale_x_q) * (2*DataW)'(sp[0]);
      py3_q   <= (2*DataW)'(scale_y_q) * (2*DataW)'(sp[1]);
      pz3_q   <= ZW'(sp[2]) * signed'(ZW'(ZScale));
      w3_q    <= sp[3];
      side3_q <= side_d;

      num4_q[LANE_X] <= DivW'(magx);
      num4_q[LANE_Y] <= DivW'(magy);
      num4_q[LANE_Z] <= DivW'(magz) << FracBits;
      den4_q         <= w3_q[DataW-1] ? DataW'(-w3_q) : DataW'(w3_q);
      side4_q        <= side4_d;
    end
  end

  vpo_div #(.DivW(DivW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (v4_q),
    .num_i   (num4_q),
    .den_i   (den4_q),
    .side_i  (side4_q),
    .valid_o (dv_valid),
    .quot_o  (quot),
    .side_o  (dv_side)
  );

  // Restore quotient signs
  always_comb begin
    for (int l = 0; l < NumLanes; l++) begin
      qs[l] = dv_side.neg[l] ? -signed'({1'b0, quot[l]}) : signed'({1'b0, quot[l]});
    end
  end

  // Map to screen, clamp, and zero when not projected
  always_ff @(posedge clk_i) begin
    if (adv) begin
      outcode_o       <= dv_side.outcode;
      projected_o     <= dv_side.projected;
      behind_eye_o    <= dv_side.behind_eye;
      w_zero_o        <= dv_side.w_zero;
      last_of_batch_o <= dv_side.last;
      if (dv_side.projected) begin
        screen_x_o <= sat32(SatW'(qs[LANE_X]) + SatW'(offset_x_q));
        screen_y_o <= sat32(SatW'(qs[LANE_Y]) + SatW'(offset_y_q));
        screen_z_o <= sat32(SatW'(qs[LANE_Z]));
      end else begin
        screen_x_o <= '0;
        screen_y_o <= '0;
        screen_z_o <= '0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire
